### rtl/asc_pkg.sv
// Shared types and constants for the accelerometer step counter.
package asc_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic [31:0] steps_total;
    logic [15:0] magnitude;
    logic [15:0] window_mean;
    logic [1:0]  walk_mode;
    logic        step_seen;
  } out_t;

  // walk mode codes
  localparam logic [1:0] ModeIdle    = 2'd0;
  localparam logic [1:0] ModePending = 2'd1;
  localparam logic [1:0] ModeWalking = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CfgPeakDropMin   = 3'd0;
  localparam logic [2:0] CfgVarianceMin   = 3'd1;
  localparam logic [2:0] CfgDebounceMs    = 3'd2;
  localparam logic [2:0] CfgConfirmWindow = 3'd3;
  localparam logic [2:0] CfgConfirmSteps  = 3'd4;
  localparam logic [2:0] CfgWalkTimeout   = 3'd5;
  localparam logic [2:0] CfgPeakHold      = 3'd6;

  localparam logic [15:0] ResetMag = 16'd17000;

  localparam logic [15:0] RstPeakDropMin   = 16'd2000;
  localparam logic [31:0] RstVarianceMin   = 32'd800000;
  localparam logic [15:0] RstDebounceMs    = 16'd300;
  localparam logic [15:0] RstConfirmWindow = 16'd3000;
  localparam logic [3:0]  RstConfirmSteps  = 4'd2;
  localparam logic [15:0] RstWalkTimeout   = 16'd2000;
  localparam logic [15:0] RstPeakHold      = 16'd2000;

endpackage

### rtl/accel_step_counter.sv
// Accelerometer step counter: magnitude, window statistics, step detection and walk machine.
// Steps per sample: the squares, the one-bit-per-cycle root, window update and reciprocal mean,
// the variance pass on the shared 17x17 multiplier, then the decision.
// A new sample is taken only once the last one is done; a waiting result holds the next one.
// Reset (async, active low): window reads 17000 via valid bits, state clears, regs default.
module accel_step_counter
  import asc_pkg::*;
#(
  parameter int MEAN_DEPTH = 20,
  parameter int VAR_DEPTH  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AddrW  = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int SumW   = 16 + $clog2(MEAN_DEPTH + 1);
  localparam int VarN   = (VAR_DEPTH < MEAN_DEPTH) ? VAR_DEPTH : MEAN_DEPTH;
  localparam int AccW   = 32 + $clog2(VarN + 1);
  localparam int ThrW   = 33 + $clog2(VAR_DEPTH + 1);
  localparam int CntTop = (VarN + 2 > 16) ? VarN + 2 : 16;
  localparam int CntW   = $clog2(CntTop + 1);
  // reciprocal of the window depth, exact for every window sum
  localparam int     RecipK = SumW + 6;
  localparam longint RecipL = ((longint'(1) << RecipK) + MEAN_DEPTH - 1) / MEAN_DEPTH;

  localparam logic [SumW-1:0]   SumReset = SumW'(int'(ResetMag) * MEAN_DEPTH);
  localparam logic [RecipK-1:0] Recip    = RecipK'(RecipL);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(MEAN_DEPTH - 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq   = 4'd1;
  localparam logic [3:0] StRoot = 4'd2;
  localparam logic [3:0] StOld  = 4'd3;
  localparam logic [3:0] StUpd  = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StVar  = 4'd6;
  localparam logic [3:0] StFin  = 4'd7;

  logic [3:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // config
  logic [15:0] pdm_q, deb_q, cwin_q, wto_q, phold_q;
  logic [31:0] vmin_q;
  logic [3:0]  csteps_q;

  // sample and datapath
  in_t smp_q, smp_d;
  logic signed [16:0] op;
  logic signed [33:0] prod_q;
  logic [31:0] sq_q, sq_d;
  logic [17:0] rem_q, rem_d;
  logic [19:0] rem_sh;
  logic [19:0] trial;
  logic [15:0] root_q, root_d;
  logic [31:0] nsh_q, nsh_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SumW+RecipK-1:0] mprod;
  logic [15:0] quot_q, quot_d;
  logic [AccW-1:0] vacc_q, vacc_d;
  logic rdv_q, rdv_d, pv_q, pv_d;
  logic [AddrW-1:0] pos_q, pos_d, idx_q, idx_d, rd_addr;

  // window memory
  logic [15:0] mem_q [MEAN_DEPTH];
  logic [MEAN_DEPTH-1:0] wvld_q;
  logic [15:0] rdata_q;
  logic rvld_q;
  logic [15:0] word;
  logic wr_en;

  // tracking state
  logic [15:0] prev_mag_q, prev_mean_q, peak_q;
  logic peak_vld_q;
  logic [31:0] peak_since_q, pend_since_q, last_det_q, last_cnt_q, total_q;
  logic [1:0] mode_q;
  logic [3:0] pend_q;

  logic out_valid_q;
  out_t out_q;

  logic in_xfer, fin_go;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign fin_go      = (state_q == StFin) && !(out_valid_q && out_stall_i);

  assign word = rvld_q ? rdata_q : ResetMag;

  // shared multiplier operand
  always_comb begin
    op = '0;
    if (state_q == StSq) begin
      case (cnt_q[1:0])
        2'd0:    op = 17'(smp_q.accel_x);
        2'd1:    op = 17'(smp_q.accel_y);
        default: op = 17'(smp_q.accel_z);
      endcase
    end else begin
      op = $signed({1'b0, word}) - $signed({1'b0, quot_q});
    end
  end

  assign rem_sh = {rem_q, nsh_q[31:30]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign mprod  = sum_q * Recip;
  assign rd_addr = (state_q == StVar) ? idx_q : pos_q;
  assign wr_en  = (state_q == StUpd);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    smp_d   = smp_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    root_d  = root_q;
    nsh_d   = nsh_q;
    sum_d   = sum_q;
    quot_d  = quot_q;
    vacc_d  = vacc_q;
    rdv_d   = 1'b0;
    pv_d    = rdv_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          smp_d   = in_data_i;
          cnt_d   = '0;
          sq_d    = '0;
          state_d = StSq;
        end
      end
      StSq: begin
        if (cnt_q != '0) sq_d = sq_q + prod_q[31:0];
        if (cnt_q == CntW'(3)) begin
          rem_d   = '0;
          root_d  = '0;
          nsh_d   = sq_d;
          cnt_d   = '0;
          state_d = StRoot;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRoot: begin
        if (rem_sh >= trial) begin
          rem_d  = 18'(rem_sh - trial);
          root_d = {root_q[14:0], 1'b1};
        end else begin
          rem_d  = 18'(rem_sh);
          root_d = {root_q[14:0], 1'b0};
        end
        nsh_d = {nsh_q[29:0], 2'b00};
        if (cnt_q == CntW'(15)) begin
          state_d = StOld;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StOld: begin
        state_d = StUpd;
      end
      StUpd: begin
        sum_d   = sum_q - SumW'(word) + SumW'(root_q);
        cnt_d   = '0;
        idx_d   = pos_q;
        pos_d   = (pos_q == LastAddr) ? '0 : pos_q + 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        quot_d  = mprod[RecipK +: 16];
        cnt_d   = '0;
        vacc_d  = '0;
        pv_d    = 1'b0;
        state_d = StVar;
      end
      StVar: begin
        // read, square and accumulate overlap, each following the one before in the next cycle
        if (cnt_q < CntW'(VarN)) begin
          rdv_d = 1'b1;
          idx_d = (idx_q == '0) ? LastAddr : idx_q - 1'b1;
        end
        if (pv_q) vacc_d = vacc_q + AccW'(prod_q[31:0]);
        if (cnt_q == CntW'(VarN + 1)) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        if (fin_go) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // detection and walk machine
  logic [15:0] mag, mean, pk_n;
  logic        pkv_n, crossed, drop_ok, var_ok, deb_ok, det;
  logic [ThrW-1:0] thr;
  logic [4:0]  ps_inc;
  logic [1:0]  mode_n;
  logic [3:0]  pend_n;
  logic [31:0] total_n, pend_since_n, last_det_n, last_cnt_n, peak_since_n, now;
  logic [15:0] pk_f;
  logic        pkv_f;

  always_comb begin
    mag  = root_q;
    mean = quot_q;
    now  = smp_q.time_ms;
    pk_n  = (mag > peak_q) ? mag : peak_q;
    pkv_n = (mag > peak_q) ? 1'b1 : peak_vld_q;
    thr   = ThrW'({1'b0, vmin_q} + 33'd1) * ThrW'(VAR_DEPTH);
    crossed  = (mag < mean) && (prev_mag_q >= prev_mean_q);
    drop_ok  = pkv_n && ((pk_n - mag) >= pdm_q);
    var_ok   = (ThrW'(vacc_q) >= thr);
    deb_ok   = ((now - last_cnt_q) > 32'(deb_q));
    det      = crossed && drop_ok && var_ok && deb_ok;
    ps_inc   = {1'b0, pend_q} + 5'd1;

    mode_n       = mode_q;
    pend_n       = pend_q;
    total_n      = total_q;
    pend_since_n = pend_since_q;
    last_det_n   = last_det_q;
    last_cnt_n   = last_cnt_q;
    if (det) begin
      last_det_n = now;
      case (mode_q)
        ModeIdle: begin
          mode_n       = ModePending;
          pend_since_n = now;
          pend_n       = 4'd1;
        end
        ModePending: begin
          pend_n = ps_inc[3:0];
          if (ps_inc >= {1'b0, csteps_q}) begin
            total_n    = total_q + 32'(ps_inc);
            last_cnt_n = now;
            pend_n     = '0;
            mode_n     = ModeWalking;
          end
        end
        default: begin
          total_n    = total_q + 32'd1;
          last_cnt_n = now;
        end
      endcase
    end
    if (mode_n == ModePending && (now - pend_since_n) > 32'(cwin_q)) begin
      mode_n = ModeIdle;
      pend_n = '0;
    end
    if (mode_n == ModeWalking && (now - last_det_n) > 32'(wto_q)) begin
      mode_n = ModeIdle;
    end

    peak_since_n = (pkv_n && !peak_vld_q) ? now : peak_since_q;
    pk_f  = pk_n;
    pkv_f = pkv_n;
    if (pkv_n && (now - peak_since_n) > 32'(phold_q)) begin
      pk_f  = '0;
      pkv_f = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      sum_q        <= SumReset;
      pos_q        <= '0;
      wvld_q       <= '0;
      rdv_q        <= 1'b0;
      pv_q         <= 1'b0;
      prev_mag_q   <= '0;
      prev_mean_q  <= '0;
      peak_q       <= '0;
      peak_vld_q   <= 1'b0;
      peak_since_q <= '0;
      mode_q       <= ModeIdle;
      pend_q       <= '0;
      pend_since_q <= '0;
      last_det_q   <= '0;
      last_cnt_q   <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      pdm_q        <= RstPeakDropMin;
      vmin_q       <= RstVarianceMin;
      deb_q        <= RstDebounceMs;
      cwin_q       <= RstConfirmWindow;
      csteps_q     <= RstConfirmSteps;
      wto_q        <= RstWalkTimeout;
      phold_q      <= RstPeakHold;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      pos_q   <= pos_d;
      rdv_q   <= rdv_d;
      pv_q    <= pv_d;
      if (wr_en) wvld_q[pos_q] <= 1'b1;
      if (fin_go) begin
        prev_mag_q   <= mag;
        prev_mean_q  <= mean;
        peak_q       <= pk_f;
        peak_vld_q   <= pkv_f;
        peak_since_q <= peak_since_n;
        mode_q       <= mode_n;
        pend_q       <= pend_n;
        pend_since_q <= pend_since_n;
        last_det_q   <= last_det_n;
        last_cnt_q   <= last_cnt_n;
        total_q      <= total_n;
        out_valid_q  <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgPeakDropMin:   pdm_q    <= cfg_data_i[15:0];
          CfgVarianceMin:   vmin_q   <= cfg_data_i;
          CfgDebounceMs:    deb_q    <= cfg_data_i[15:0];
          CfgConfirmWindow: cwin_q   <= cfg_data_i[15:0];
          CfgConfirmSteps:  csteps_q <= cfg_data_i[3:0];
          CfgWalkTimeout:   wto_q    <= cfg_data_i[15:0];
          CfgPeakHold:      phold_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    prod_q  <= op * op;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    nsh_q   <= nsh_d;
    quot_q  <= quot_d;
    vacc_q  <= vacc_d;
    idx_q   <= idx_d;
    rdata_q <= mem_q[rd_addr];
    rvld_q  <= wvld_q[rd_addr];
    if (wr_en) mem_q[pos_q] <= root_q;
    if (fin_go) begin
      out_q.steps_total <= total_n;
      out_q.magnitude   <= mag;
      out_q.window_mean <= mean;
      out_q.walk_mode   <= mode_n;
      out_q.step_seen   <= det;
    end
  end

endmodule

### rtl/asc_checker.sv
// Port-level checks for the accelerometer step counter, bound to the top level.
module asc_checker
  import asc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // a taken sample keeps the input side busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after sample transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a new result only comes out of work in progress
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a sample in work");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.walk_mode != 2'd3)
    else $error("unused walk mode code on output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind accel_step_counter asc_checker u_asc_checker (.*);
